[rtl/core/pls_pkg.sv]
// Shared constants, command and status codes, and the cell control type of the list store.
package pls_pkg;

   localparam int CAPACITY = 1024;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int LEN_W    = 11;
   localparam int CMP_W    = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam int WORD_W   = 32;

   localparam logic [1:0] CMD_APPEND = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic [1:0] OP_HOLD   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   typedef struct packed {
      logic [1:0]        op;
      logic [IDX_W-1:0]  pos;
      logic [WORD_W-1:0] value;
   } pls_ctrl_type;

endpackage

[rtl/core/pls_cell.sv]
// One storage cell of the list: holds a word and one stage of the extraction tap line.
module pls_cell (
   input  logic                       clock,
   input  pls_pkg::pls_ctrl_type      ctrl,
   input  logic [pls_pkg::IDX_W-1:0]  cell_index,
   input  logic [pls_pkg::WORD_W-1:0] left_data,
   input  logic [pls_pkg::WORD_W-1:0] right_data,
   input  logic [pls_pkg::WORD_W-1:0] right_tap,
   output logic [pls_pkg::WORD_W-1:0] data,
   output logic [pls_pkg::WORD_W-1:0] tap
);

   logic [pls_pkg::WORD_W-1:0] data_ff, data_in;
   logic [pls_pkg::WORD_W-1:0] tap_ff, tap_in;

   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         pls_pkg::OP_INSERT: begin
            if (cell_index == ctrl.pos) begin
               data_in = ctrl.value;
            end else if (cell_index > ctrl.pos) begin
               data_in = left_data;
            end
         end
         pls_pkg::OP_DELETE: begin
            if (cell_index >= ctrl.pos) begin
               data_in = right_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   // Capture the word being deleted, otherwise advance the tap toward cell 0.
   assign tap_in = (ctrl.op == pls_pkg::OP_DELETE && cell_index == ctrl.pos) ? data_ff
                                                                             : right_tap;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      tap_ff  <= tap_in;
   end

   assign data = data_ff;
   assign tap  = tap_ff;

endmodule

[rtl/core/pls_cell_row.sv]
// Row of list cells linked to their neighbors; the tap line ends at cell 0.
module pls_cell_row (
   input  logic                       clock,
   input  pls_pkg::pls_ctrl_type      ctrl,
   output logic [pls_pkg::WORD_W-1:0] tap_out
);

   logic [pls_pkg::WORD_W-1:0] data_w [pls_pkg::CAPACITY];
   logic [pls_pkg::WORD_W-1:0] tap_w  [pls_pkg::CAPACITY];

   for (genvar i = 0; i < pls_pkg::CAPACITY; i++) begin : g_cell
      logic [pls_pkg::WORD_W-1:0] left_w, right_w, rtap_w;

      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = data_w[i-1];
      end

      if (i == pls_pkg::CAPACITY - 1) begin : g_last
         assign right_w = '0;
         assign rtap_w  = '0;
      end else begin : g_mid_r
         assign right_w = data_w[i+1];
         assign rtap_w  = tap_w[i+1];
      end

      pls_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_index (pls_pkg::IDX_W'(i)),
         .left_data  (left_w),
         .right_data (right_w),
         .right_tap  (rtap_w),
         .data       (data_w[i]),
         .tap        (tap_w[i])
      );
   end

   assign tap_out = tap_w[0];

endmodule

[rtl/core/positional_list_shift_store_core.sv]
// Top level of the positional list store: command decode, length count and result registers.
//
// An ordered list of up to CAPACITY signed 32-bit words held in a row of cells. Append, insert
// and delete each take one transaction (start high while busy is low) and give exactly one
// result, shown on the rsp_ ports for one cycle with rsp_strobe high; the receiver cannot stall
// it, so sample it on that cycle. Append, insert, refused commands and the unused command code
// produce their result the cycle after acceptance and leave busy low, so a new transaction may
// follow in the very next cycle. A successful delete shifts the whole list but the removed
// word walks down the cells' tap line one cell per cycle toward cell 0: busy stays high until
// the word reaches cell 0, and the result is registered from cell 0's tap. The next
// transaction may be accepted in the cycle the delete result is shown. No clearing pass is
// needed after reset: only entries below the length are ever read.
module positional_list_shift_store_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_cmd,
   input  logic signed [pls_pkg::WORD_W-1:0] req_value,
   input  logic [pls_pkg::LEN_W-1:0]         req_position,
   output logic                              rsp_strobe,
   output logic [1:0]                        rsp_status,
   output logic [pls_pkg::LEN_W-1:0]         rsp_length,
   output logic signed [pls_pkg::WORD_W-1:0] rsp_removed_value
);

   logic [pls_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                       busy_ff, busy_in;
   logic [pls_pkg::IDX_W-1:0]  wait_ff, wait_in;
   logic                       rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]                 rsp_status_ff, rsp_status_in;
   logic [pls_pkg::LEN_W-1:0]  rsp_length_ff, rsp_length_in;
   logic [pls_pkg::WORD_W-1:0] rsp_removed_ff, rsp_removed_in;

   logic                       accept;
   logic                       drain_done;
   logic [pls_pkg::CMP_W-1:0]  cnt_x, pos_x, len_x;
   logic [1:0]                 dec_status;
   logic [1:0]                 dec_op;
   logic [pls_pkg::IDX_W-1:0]  dec_pos;
   logic [pls_pkg::CNT_W-1:0]  dec_count;
   logic                       full;
   pls_pkg::pls_ctrl_type      ctrl;
   logic [pls_pkg::WORD_W-1:0] tap0;

   assign accept     = start && !busy_ff;
   assign drain_done = busy_ff && (wait_ff == '0);
   assign cnt_x      = pls_pkg::CMP_W'(count_ff);
   assign pos_x      = pls_pkg::CMP_W'(req_position);
   assign full       = (count_ff >= pls_pkg::CNT_W'(pls_pkg::CAPACITY));

   // Decode the command against the current length; append is an insert at the end.
   always_comb begin
      dec_status = pls_pkg::ST_DONE;
      dec_op     = pls_pkg::OP_HOLD;
      dec_pos    = pos_x[pls_pkg::IDX_W-1:0];
      dec_count  = count_ff;
      case (req_cmd)
         pls_pkg::CMD_APPEND: begin
            dec_pos = count_ff[pls_pkg::IDX_W-1:0];
            if (full) begin
               dec_status = pls_pkg::ST_FULL;
            end else begin
               dec_op    = pls_pkg::OP_INSERT;
               dec_count = pls_pkg::CNT_W'(count_ff + 1'b1);
            end
         end
         pls_pkg::CMD_INSERT: begin
            if (pos_x > cnt_x) begin
               dec_status = pls_pkg::ST_RANGE;
            end else if (full) begin
               dec_status = pls_pkg::ST_FULL;
            end else begin
               dec_op    = pls_pkg::OP_INSERT;
               dec_count = pls_pkg::CNT_W'(count_ff + 1'b1);
            end
         end
         pls_pkg::CMD_DELETE: begin
            if (pos_x >= cnt_x) begin
               dec_status = pls_pkg::ST_RANGE;
            end else begin
               dec_op    = pls_pkg::OP_DELETE;
               dec_count = pls_pkg::CNT_W'(count_ff - 1'b1);
            end
         end
         default: dec_status = pls_pkg::ST_DONE;
      endcase
   end

   // Cells hold unless a transaction is accepted this cycle.
   always_comb begin
      ctrl.op    = accept ? dec_op : pls_pkg::OP_HOLD;
      ctrl.pos   = dec_pos;
      ctrl.value = req_value;
   end

   pls_cell_row u_row (
      .clock   (clock),
      .ctrl    (ctrl),
      .tap_out (tap0)
   );

   assign len_x = pls_pkg::CMP_W'(dec_count);

   always_comb begin
      count_in       = accept ? dec_count : count_ff;
      busy_in        = busy_ff;
      wait_in        = wait_ff;
      rsp_strobe_in  = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_length_in  = rsp_length_ff;
      rsp_removed_in = rsp_removed_ff;
      if (drain_done) begin
         // Removed word has reached cell 0: release busy and report it.
         busy_in        = 1'b0;
         rsp_strobe_in  = 1'b1;
         rsp_status_in  = pls_pkg::ST_DONE;
         rsp_length_in  = cnt_x[pls_pkg::LEN_W-1:0];
         rsp_removed_in = tap0;
      end else if (busy_ff) begin
         wait_in = pls_pkg::IDX_W'(wait_ff - 1'b1);
      end else if (accept) begin
         if (dec_op == pls_pkg::OP_DELETE) begin
            // Hold the result until the tap line delivers the word.
            busy_in = 1'b1;
            wait_in = dec_pos;
         end else begin
            rsp_strobe_in  = 1'b1;
            rsp_status_in  = dec_status;
            rsp_length_in  = len_x[pls_pkg::LEN_W-1:0];
            rsp_removed_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         busy_ff       <= busy_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      wait_ff        <= wait_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_length_ff  <= rsp_length_in;
      rsp_removed_ff <= rsp_removed_in;
   end

   assign busy              = busy_ff;
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_length        = rsp_length_ff;
   assign rsp_removed_value = rsp_removed_ff;

endmodule
